[hw/rtl/stdf_pkg.sv]
package stdf_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 11;
    localparam int LEN_W   = 10;
    localparam int CRC_W   = 16;
    localparam int IDX_W   = 9;
    localparam int DIST_W  = 15;
    localparam int PART_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h8005;
    localparam logic [BYTE_W-1:0] CMD_DIST   = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_REMIS  = 8'hF5;
    localparam logic [15:0]       REMIS_MAX  = 16'd32759;

    localparam logic [BYTE_W-1:0] START_RESET = 8'd2;
    localparam logic [BYTE_W-1:0] ADDR_RESET  = 8'd128;
    localparam logic [BYTE_W-1:0] MASK_RESET  = 8'h1f;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd2;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] distance_mask;
    } t_cfg;

    typedef struct packed {
        logic              result_kind;
        logic [IDX_W-1:0]  point_index;
        logic [DIST_W-1:0] distance;
        logic [DIST_W-1:0] remission;
        logic              has_remission;
        logic              crc_ok;
        logic [PART_W-1:0] scan_part;
        logic [IDX_W-1:0]  point_count;
    } t_result;

    // One pair-byte step: shift the register, fold in the polynomial, xor the byte pair.
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] prev,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = {crc[CRC_W-2:0], 1'b0};
        if (crc[CRC_W-1]) begin
            c = c ^ CRC_POLY;
        end
        return c ^ {prev, b};
    endfunction

endpackage

[hw/rtl/stdf_parser.sv]
module stdf_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [stdf_pkg::BYTE_W-1:0]   i_byte,
    input  stdf_pkg::t_cfg                i_cfg,
    output stdf_pkg::t_result             o_res,
    output logic                          o_res_valid
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_ADDR, PH_LENLO, PH_LENHI, PH_CMD, PH_DATA, PH_CRCLO, PH_CRCHI
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [stdf_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [stdf_pkg::LEN_W-1:0]          r_len, n_len;
    logic                                r_rem_type, n_rem_type;
    logic [stdf_pkg::CRC_W-1:0]          r_crc, n_crc;
    logic [stdf_pkg::BYTE_W-1:0]         r_prev, n_prev;
    logic [stdf_pkg::BYTE_W-1:0]         r_held_lo, n_held_lo;
    logic [stdf_pkg::DIST_W-1:0]         r_held_dist, n_held_dist;
    logic [stdf_pkg::IDX_W-1:0]          r_decl, n_decl;
    logic [stdf_pkg::IDX_W-1:0]          r_done, n_done;
    logic [stdf_pkg::PART_W-1:0]         r_part, n_part;
    logic [stdf_pkg::BYTE_W-1:0]         r_crc_lo, n_crc_lo;

    logic [stdf_pkg::CRC_W-1:0]          crc_fed;
    logic [stdf_pkg::DIST_W-1:0]         dist_now;
    logic [15:0]                         rem_raw;
    logic [stdf_pkg::POS_W-1:0]          q_dist, q_remis;
    logic [stdf_pkg::POS_W-1:0]          len_end;

    assign crc_fed  = stdf_pkg::crc_step(r_crc, r_prev, i_byte);
    assign dist_now = {i_byte[6:0] & i_cfg.distance_mask[6:0], r_held_lo};
    assign rem_raw  = {i_byte, r_held_lo};
    assign q_dist   = r_pos - stdf_pkg::POS_W'(7);
    assign q_remis  = r_pos - stdf_pkg::POS_W'(13);
    assign len_end  = stdf_pkg::POS_W'(r_len) + stdf_pkg::POS_W'(3);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_len       = r_len;
        n_rem_type  = r_rem_type;
        n_crc       = r_crc;
        n_prev      = r_prev;
        n_held_lo   = r_held_lo;
        n_held_dist = r_held_dist;
        n_decl      = r_decl;
        n_done      = r_done;
        n_part      = r_part;
        n_crc_lo    = r_crc_lo;
        o_res_valid = 1'b0;
        o_res.result_kind   = stdf_pkg::KIND_POINT;
        o_res.point_index   = r_done;
        o_res.distance      = dist_now;
        o_res.remission     = '0;
        o_res.has_remission = r_rem_type;
        o_res.crc_ok        = 1'b0;
        o_res.scan_part     = r_part;
        o_res.point_count   = r_decl;

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.start_byte) begin
                    n_crc   = stdf_pkg::crc_step('0, '0, i_byte);
                    n_prev  = i_byte;
                    n_pos   = stdf_pkg::POS_W'(1);
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (i_byte == i_cfg.address_byte) begin
                    n_crc   = crc_fed;
                    n_prev  = i_byte;
                    n_pos   = stdf_pkg::POS_W'(2);
                    n_phase = PH_LENLO;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LENLO: begin
                n_crc   = crc_fed;
                n_prev  = i_byte;
                n_len   = stdf_pkg::LEN_W'(i_byte);
                n_pos   = stdf_pkg::POS_W'(3);
                n_phase = PH_LENHI;
            end
            PH_LENHI: begin
                n_crc   = crc_fed;
                n_prev  = i_byte;
                n_len   = {i_byte[1:0], r_len[7:0]};
                n_pos   = stdf_pkg::POS_W'(4);
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                if ((i_byte != stdf_pkg::CMD_DIST && i_byte != stdf_pkg::CMD_REMIS)
                        || r_len == '0) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_crc      = crc_fed;
                    n_prev     = i_byte;
                    n_rem_type = (i_byte == stdf_pkg::CMD_REMIS);
                    if (i_byte == stdf_pkg::CMD_REMIS || r_len < stdf_pkg::LEN_W'(4)) begin
                        n_decl = '0;
                    end else begin
                        n_decl = stdf_pkg::IDX_W'((r_len - stdf_pkg::LEN_W'(4)) >> 1);
                    end
                    n_done      = '0;
                    n_part      = '0;
                    n_held_lo   = '0;
                    n_held_dist = '0;
                    n_pos       = stdf_pkg::POS_W'(5);
                    n_phase     = (r_len == stdf_pkg::LEN_W'(1)) ? PH_CRCLO : PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc  = crc_fed;
                n_prev = i_byte;
                if (r_pos == stdf_pkg::POS_W'(6)) begin
                    n_part = i_byte[4:3];
                end
                if (!r_rem_type) begin
                    if (r_pos >= stdf_pkg::POS_W'(7)
                            && q_dist[stdf_pkg::POS_W-1:1] < (stdf_pkg::POS_W-1)'(r_decl)) begin
                        if (!q_dist[0]) begin
                            n_held_lo = i_byte;
                        end else begin
                            n_held_dist = dist_now;
                            o_res_valid = 1'b1;
                            n_done      = r_done + stdf_pkg::IDX_W'(1);
                        end
                    end
                end else begin
                    if (r_pos == stdf_pkg::POS_W'(11)) begin
                        n_decl = stdf_pkg::IDX_W'(i_byte);
                    end
                    if (r_pos >= stdf_pkg::POS_W'(13)
                            && q_remis[stdf_pkg::POS_W-1:2] < (stdf_pkg::POS_W-2)'(r_decl)) begin
                        case (q_remis[1:0])
                            2'd0, 2'd2: n_held_lo = i_byte;
                            2'd1:       n_held_dist = dist_now;
                            default: begin
                                o_res.distance  = r_held_dist;
                                o_res.remission = (rem_raw > stdf_pkg::REMIS_MAX)
                                                  ? '0 : rem_raw[stdf_pkg::DIST_W-1:0];
                                o_res_valid     = 1'b1;
                                n_done          = r_done + stdf_pkg::IDX_W'(1);
                            end
                        endcase
                    end
                end
                if (r_pos >= len_end) begin
                    n_phase = PH_CRCLO;
                end
                n_pos = r_pos + stdf_pkg::POS_W'(1);
            end
            PH_CRCLO: begin
                n_crc_lo = i_byte;
                n_pos    = r_pos + stdf_pkg::POS_W'(1);
                n_phase  = PH_CRCHI;
            end
            default: begin
                o_res.result_kind = stdf_pkg::KIND_END;
                o_res.point_index = '0;
                o_res.distance    = '0;
                o_res.crc_ok      = (r_crc == {i_byte, r_crc_lo});
                o_res_valid       = 1'b1;
                n_pos             = '0;
                n_phase           = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_pos       <= '0;
            r_len       <= '0;
            r_rem_type  <= 1'b0;
            r_crc       <= '0;
            r_prev      <= '0;
            r_held_lo   <= '0;
            r_held_dist <= '0;
            r_decl      <= '0;
            r_done      <= '0;
            r_part      <= '0;
            r_crc_lo    <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_rem_type  <= n_rem_type;
            r_crc       <= n_crc;
            r_prev      <= n_prev;
            r_held_lo   <= n_held_lo;
            r_held_dist <= n_held_dist;
            r_decl      <= n_decl;
            r_done      <= n_done;
            r_part      <= n_part;
            r_crc_lo    <= n_crc_lo;
        end
    end

endmodule

[hw/rtl/stdf_out_reg.sv]
module stdf_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_res_valid,
    input  stdf_pkg::t_result  i_res,
    input  logic               i_ready,
    output logic               o_valid,
    output stdf_pkg::t_result  o_res,
    output logic               o_free
);

    logic              r_valid;
    stdf_pkg::t_result r_res;

    // Slot is free when empty or when the held word leaves this cycle.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

[hw/rtl/scan_telegram_deframer.sv]
// A result passes through the input register and then the result register after its byte is accepted.
// One byte per cycle while the result slot is free; the parser state register closes the loop.
// A byte whose result cannot yet be placed waits in the input register until the result
// register drains.
// Reset (synchronous, active low): hunting for the start byte, registers to their defaults.
module scan_telegram_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [stdf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [stdf_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [stdf_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_result_kind,
    output logic [stdf_pkg::IDX_W-1:0]      o_point_index,
    output logic [stdf_pkg::DIST_W-1:0]     o_distance,
    output logic [stdf_pkg::DIST_W-1:0]     o_remission,
    output logic                            o_has_remission,
    output logic                            o_crc_ok,
    output logic [stdf_pkg::PART_W-1:0]     o_scan_part,
    output logic [stdf_pkg::IDX_W-1:0]      o_point_count
);

    stdf_pkg::t_cfg              r_cfg;
    logic                        r_in_valid;
    logic [stdf_pkg::BYTE_W-1:0] r_in_byte;
    logic                        step;
    logic                        out_free;
    logic                        res_valid;
    stdf_pkg::t_result           res;
    stdf_pkg::t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= stdf_pkg::START_RESET;
            r_cfg.address_byte  <= stdf_pkg::ADDR_RESET;
            r_cfg.distance_mask <= stdf_pkg::MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stdf_pkg::CFG_START: r_cfg.start_byte    <= i_cfg_data;
                stdf_pkg::CFG_ADDR:  r_cfg.address_byte  <= i_cfg_data;
                stdf_pkg::CFG_MASK:  r_cfg.distance_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the held byte whenever the result slot can take its outcome.
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    stdf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    stdf_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (i_out_ready),
        .o_valid     (o_out_valid),
        .o_res       (out_res),
        .o_free      (out_free)
    );

    assign o_result_kind   = out_res.result_kind;
    assign o_point_index   = out_res.point_index;
    assign o_distance      = out_res.distance;
    assign o_remission     = out_res.remission;
    assign o_has_remission = out_res.has_remission;
    assign o_crc_ok        = out_res.crc_ok;
    assign o_scan_part     = out_res.scan_part;
    assign o_point_count   = out_res.point_count;

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT, PH_ADDR, PH_LEN_LO, PH_LEN_HI, PH_CMD, PH_DATA, PH_CRC_LO, PH_CRC_HI
    } t_parse_phase;

    localparam logic [BYTE_W-1:0] CMD_UNKNOWN = 8'hA5;
    localparam logic [CRC_W-1:0]  POLY_8005   = 16'h8005;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [BYTE_W-1:0]     i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_result_kind;
    logic [IDX_W-1:0]      o_point_index;
    logic [DIST_W-1:0]     o_distance;
    logic [DIST_W-1:0]     o_remission;
    logic                  o_has_remission;
    logic                  o_crc_ok;
    logic [PART_W-1:0]     o_scan_part;
    logic [IDX_W-1:0]      o_point_count;

    scan_telegram_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_point_index   (o_point_index),
        .o_distance      (o_distance),
        .o_remission     (o_remission),
        .o_has_remission (o_has_remission),
        .o_crc_ok        (o_crc_ok),
        .o_scan_part     (o_scan_part),
        .o_point_count   (o_point_count)
    );

    // Deframer state as the testbench tracks it
    logic [BYTE_W-1:0] cfg_start = START_RESET;
    logic [BYTE_W-1:0] cfg_addr  = ADDR_RESET;
    logic [BYTE_W-1:0] cfg_mask  = MASK_RESET;

    t_parse_phase      ph        = PH_HUNT;
    logic [POS_W-1:0]  pos       = '0;
    logic [LEN_W-1:0]  msg_len   = '0;
    logic              rem_type  = 1'b0;
    logic [CRC_W-1:0]  crc_acc   = '0;
    logic [BYTE_W-1:0] prev_byte = '0;
    logic [BYTE_W-1:0] held_lo   = '0;
    logic [DIST_W-1:0] held_dist = '0;
    logic [IDX_W-1:0]  n_decl    = '0;
    logic [IDX_W-1:0]  n_done    = '0;
    logic [PART_W-1:0] part      = '0;
    logic [BYTE_W-1:0] crc_lo    = '0;

    t_result           pending_results[$];
    logic [BYTE_W-1:0] frame[$];
    logic [BYTE_W-1:0] payload[$];

    int mismatches  = 0;
    int bytes_sent  = 0;
    int rx_hold     = 0;
    bit rx_steady   = 1'b0;
    bit tx_steady   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return int'($urandom_range(10, 40));
        end
        return int'($urandom_range(1, 3));
    endfunction

    function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] p,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] n;
        n = {c[CRC_W-2:0], 1'b0};
        if (c[CRC_W-1]) begin
            n = n ^ POLY_8005;
        end
        return n ^ {p, b};
    endfunction

    function automatic void crc_feed(input logic [BYTE_W-1:0] b);
        crc_acc   = crc_next(crc_acc, prev_byte, b);
        prev_byte = b;
    endfunction

    function automatic void push_result(input logic kind, input logic [IDX_W-1:0] idx,
                                        input logic [DIST_W-1:0] dist_val,
                                        input logic [DIST_W-1:0] rem, input logic ok);
        t_result r;
        r.result_kind   = kind;
        r.point_index   = idx;
        r.distance      = dist_val;
        r.remission     = rem;
        r.has_remission = rem_type;
        r.crc_ok        = ok;
        r.scan_part     = part;
        r.point_count   = n_decl;
        pending_results.push_back(r);
    endfunction

    // Data byte of an accepted telegram: pick up info, count and point fields
    function automatic void take_data_byte(input logic [BYTE_W-1:0] b);
        int p;
        int q;
        logic [15:0] wide;
        p = int'(pos);
        if (p == 6) part = b[4:3];
        if (!rem_type) begin
            if (p >= 7) begin
                q = p - 7;
                if ((q >> 1) < int'(n_decl)) begin
                    if (q[0] == 1'b0) begin
                        held_lo = b;
                    end else begin
                        wide      = {b & cfg_mask, held_lo};
                        held_dist = wide[DIST_W-1:0];
                        push_result(KIND_POINT, n_done, held_dist, '0, 1'b0);
                        n_done = n_done + 9'd1;
                    end
                end
            end
        end else begin
            if (p == 11) n_decl = {1'b0, b};
            if (p >= 13) begin
                q = p - 13;
                if ((q >> 2) < int'(n_decl)) begin
                    case (q[1:0])
                        2'd0, 2'd2: held_lo = b;
                        2'd1: begin
                            wide      = {b & cfg_mask, held_lo};
                            held_dist = wide[DIST_W-1:0];
                        end
                        default: begin
                            wide = {b, held_lo};
                            if (wide > REMIS_MAX) wide = '0;
                            push_result(KIND_POINT, n_done, held_dist, wide[DIST_W-1:0], 1'b0);
                            n_done = n_done + 9'd1;
                        end
                    endcase
                end
            end
        end
        if (p >= int'(msg_len) + 3) ph = PH_CRC_LO;
        pos = pos + 11'd1;
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        case (ph)
            PH_HUNT: begin
                if (b == cfg_start) begin
                    crc_acc   = '0;
                    prev_byte = '0;
                    crc_feed(b);
                    pos = 11'd1;
                    ph  = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (b == cfg_addr) begin
                    crc_feed(b);
                    pos = 11'd2;
                    ph  = PH_LEN_LO;
                end else begin
                    ph = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                crc_feed(b);
                msg_len = {2'b00, b};
                pos     = 11'd3;
                ph      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                crc_feed(b);
                msg_len = {b[1:0], msg_len[7:0]};
                pos     = 11'd4;
                ph      = PH_CMD;
            end
            PH_CMD: begin
                if ((b != CMD_DIST && b != CMD_REMIS) || msg_len == '0) begin
                    ph = PH_HUNT;
                end else begin
                    crc_feed(b);
                    rem_type = (b == CMD_REMIS);
                    if (!rem_type && msg_len >= 10'd4) begin
                        n_decl = 9'((msg_len - 10'd4) >> 1);
                    end else begin
                        n_decl = '0;
                    end
                    n_done    = '0;
                    part      = '0;
                    held_lo   = '0;
                    held_dist = '0;
                    pos       = 11'd5;
                    ph        = (msg_len == 10'd1) ? PH_CRC_LO : PH_DATA;
                end
            end
            PH_DATA: begin
                crc_feed(b);
                take_data_byte(b);
            end
            PH_CRC_LO: begin
                crc_lo = b;
                pos    = pos + 11'd1;
                ph     = PH_CRC_HI;
            end
            default: begin
                push_result(KIND_END, '0, '0, '0, crc_acc == {b, crc_lo});
                pos = '0;
                ph  = PH_HUNT;
            end
        endcase
    endfunction

    // Build a telegram from the payload queue; payload is padded with random bytes
    function automatic void make_frame(input logic [BYTE_W-1:0] cmd, input int len,
                                       input bit crc_good);
        logic [LEN_W-1:0]  l;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] pv;
        logic [CRC_W-1:0]  c;
        l       = LEN_W'(len);
        hi      = rand_byte();
        hi[1:0] = l[9:8];
        frame   = {cfg_start, cfg_addr, l[7:0], hi, cmd};
        if (len == 0 || (cmd != CMD_DIST && cmd != CMD_REMIS)) begin
            payload.delete();
            return;
        end
        while (payload.size() < len - 1) payload.push_back(rand_byte());
        for (int i = 0; i < len - 1; i++) frame.push_back(payload[i]);
        c  = '0;
        pv = '0;
        foreach (frame[i]) begin
            c  = crc_next(c, pv, frame[i]);
            pv = frame[i];
        end
        if (!crc_good) c = c ^ (16'h0001 << $urandom_range(0, 15));
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
        payload.delete();
    endfunction

    function automatic void plan_random_frame();
        int  n;
        int  cnt;
        int  len;
        bit  good;
        good = ($urandom_range(0, 99) < 85);
        n    = ($urandom_range(0, 39) == 0) ? int'($urandom_range(7, 60))
                                            : int'($urandom_range(0, 6));
        payload.delete();
        payload.push_back(rand_byte());
        payload.push_back(rand_byte());
        if ($urandom_range(0, 1) == 0) begin
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 5))
                                              : 4 + 2 * n + int'($urandom_range(0, 1));
            make_frame(CMD_DIST, len, good);
        end else begin
            cnt = n;
            if ($urandom_range(0, 6) == 0) cnt = int'($urandom_range(n, 255));
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 12))
                                              : 9 + 4 * n + int'($urandom_range(0, 3));
            repeat (4) payload.push_back(rand_byte());
            payload.push_back(8'(cnt));
            payload.push_back(rand_byte());
            repeat (n) begin
                payload.push_back(rand_byte());
                payload.push_back(rand_byte());
                // keep some remissions right at the clipping edge
                if ($urandom_range(0, 3) == 0) begin
                    payload.push_back(8'($urandom_range(8'hf6, 8'hf8)));
                    payload.push_back(8'h7f);
                end else begin
                    payload.push_back(rand_byte());
                    payload.push_back(rand_byte());
                end
            end
            make_frame(CMD_REMIS, len, good);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        deframe_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    // Drive filler until the parser is back to hunting; zero lengths abort quickly
    task automatic settle();
        logic [BYTE_W-1:0] b;
        while (ph != PH_HUNT) begin
            b = (ph == PH_LEN_LO || ph == PH_LEN_HI) ? 8'h00 : rand_byte();
            send_byte(b);
        end
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START: cfg_start = val;
            CFG_ADDR:  cfg_addr  = val;
            CFG_MASK:  cfg_mask  = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] a,
                                input logic [BYTE_W-1:0] m);
        wait_drain();
        write_reg(CFG_START, s);
        write_reg(CFG_ADDR, a);
        write_reg(CFG_MASK, m);
    endtask

    task automatic send_broken_frame();
        logic [BYTE_W-1:0] b;
        int keep;
        case ($urandom_range(0, 3))
            0: begin
                b = rand_byte();
                if (b == cfg_addr) b = b + 8'd1;
                if ($urandom_range(0, 2) == 0 && cfg_start != cfg_addr) b = cfg_start;
                frame = {cfg_start, b};
            end
            1: begin
                b = rand_byte();
                if (b == CMD_DIST || b == CMD_REMIS) b = b ^ 8'h01;
                make_frame(b, int'($urandom_range(1, 40)), 1'b1);
            end
            2: make_frame(($urandom_range(0, 1) == 0) ? CMD_DIST : CMD_REMIS, 0, 1'b1);
            default: begin
                plan_random_frame();
                keep = int'($urandom_range(1, frame.size() - 1));
                while (frame.size() > keep) void'(frame.pop_back());
            end
        endcase
        send_frame();
    endtask

    task automatic run_traffic(input int n_bytes);
        int first;
        int pick;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            if ($urandom_range(0, 11) == 0) tx_steady = !tx_steady;
            if ($urandom_range(0, 11) == 0) rx_steady = !rx_steady;
            pick = int'($urandom_range(0, 99));
            if (pick < 78) begin
                plan_random_frame();
                send_frame();
            end else if (pick < 90) begin
                send_broken_frame();
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            end
            settle();
            if ($urandom_range(0, 24) == 0) wait_drain();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_directed_frames();
        // full-scale and zero distances, info part 3
        payload = {8'h00, 8'h18, 8'hff, 8'hff, 8'h00, 8'h00};
        make_frame(CMD_DIST, 8, 1'b1);
        send_frame();
        // remission at the limit, one past it, and all ones
        payload = {8'h00, 8'h10, 8'h11, 8'h22, 8'h33, 8'h44, 8'd3, 8'h55,
                   8'hff, 8'hff, 8'hf7, 8'h7f, 8'h34, 8'h12, 8'hf8, 8'h7f,
                   8'h00, 8'h00, 8'hff, 8'hff};
        make_frame(CMD_REMIS, 21, 1'b1);
        send_frame();
        payload = {8'h00, 8'h08, 8'h21, 8'h43, 8'h65};
        make_frame(CMD_DIST, 6, 1'b0);
        send_frame();
        // a start byte in the address slot is swallowed, not taken as a new start
        frame = {cfg_start, cfg_start, cfg_addr};
        send_frame();
        make_frame(CMD_DIST, 1, 1'b1);
        send_frame();
        make_frame(CMD_REMIS, 0, 1'b1);
        send_frame();
        make_frame(CMD_UNKNOWN, 5, 1'b1);
        send_frame();
        make_frame(CMD_DIST, 3, 1'b1);
        send_frame();
        make_frame(CMD_REMIS, 5, 1'b1);
        send_frame();
        // declared count far beyond the data: only one point fits
        payload = {8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'd200, 8'h00,
                   8'h01, 8'h80, 8'h02, 8'h00};
        make_frame(CMD_REMIS, 13, 1'b1);
        send_frame();
        settle();
        wait_drain();
    endtask

    task automatic test_long_frame();
        payload.delete();
        make_frame(CMD_DIST, 1023, 1'b1);
        send_frame();
        wait_drain();
    endtask

    task automatic test_backpressure();
        rx_hold   = 300;
        tx_steady = 1'b1;
        payload.delete();
        make_frame(CMD_DIST, 64, 1'b1);
        send_frame();
        tx_steady = 1'b0;
        wait_drain();
    endtask

    task automatic test_config_sweep();
        run_traffic(60);
        apply_config(8'h00, 8'hff, 8'hff);
        run_traffic(60);
        apply_config(8'hff, 8'h00, 8'h00);
        run_traffic(60);
        apply_config(8'h7e, 8'h7e, 8'h7f);
        run_traffic(60);
        apply_config(rand_byte(), rand_byte(), rand_byte());
        run_traffic(60);
    endtask

    // Receiver: random stalls, plus a long hold when one is requested
    initial begin
        int stall;
        stall       = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold--;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        t_result e;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing pending");
                    mismatches++;
                end else begin
                    e = pending_results.pop_front();
                    check_field("result_kind", e.result_kind, o_result_kind);
                    check_field("point_index", e.point_index, o_point_index);
                    check_field("distance", e.distance, o_distance);
                    check_field("remission", e.remission, o_remission);
                    check_field("has_remission", e.has_remission, o_has_remission);
                    check_field("crc_ok", e.crc_ok, o_crc_ok);
                    check_field("scan_part", e.scan_part, o_scan_part);
                    check_field("point_count", e.point_count, o_point_count);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_START;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_long_frame();
        test_backpressure();
        test_config_sweep();

        wait_drain();
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
